// File: hdl/command_line_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokenizer
// Property forms shared by the checker: overlapping and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define CLTOK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define CLTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always checked
`define CLTOK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/cltok_pkg.sv
// ----------------------------------------------------------------------------
// cltok_pkg
// Types and constants of the command line tokenizer.
// ----------------------------------------------------------------------------
package cltok_pkg;

   localparam int CHAR_W  = 16;
   localparam int INDEX_W = 8;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 16'h0009;
   localparam logic [CHAR_W-1:0] CHAR_EQ    = 16'h003D;
   localparam logic [CHAR_W-1:0] CHAR_LT    = 16'h003C;
   localparam logic [CHAR_W-1:0] CHAR_GT    = 16'h003E;
   localparam logic [CHAR_W-1:0] CHAR_PIPE  = 16'h007C;
   localparam logic [CHAR_W-1:0] CHAR_AMP   = 16'h0026;
   localparam logic [CHAR_W-1:0] CHAR_CARET = 16'h005E;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE = 16'h0022;

   // scanner state
   typedef enum logic [1:0] {
      MODE_BETWEEN  = 2'd0,
      MODE_WORD     = 2'd1,
      MODE_QUOTED   = 2'd2,
      MODE_OPERATOR = 2'd3
   } scan_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              line_last;
   } req_beat_type;

   typedef struct packed {
      logic               in_token;
      logic               token_start;
      logic [INDEX_W-1:0] token_index;
      logic               operator_token;
      logic               line_end;
   } rsp_beat_type;

endpackage

// File: hdl/cltok_channels.sv
// ----------------------------------------------------------------------------
// cltok channels
// Valid/ready channels for the character stream and the per-character marks.
// ----------------------------------------------------------------------------
interface cltok_req_if import cltok_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              line_last;

   modport source (output valid, character, line_last, input ready);
   modport sink   (input valid, character, line_last, output ready);
endinterface

interface cltok_rsp_if import cltok_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               in_token;
   logic               token_start;
   logic [INDEX_W-1:0] token_index;
   logic               operator_token;
   logic               line_end;

   modport source (output valid, in_token, token_start, token_index, operator_token,
                   line_end, input ready);
   modport sink   (input valid, in_token, token_start, token_index, operator_token,
                   line_end, output ready);
endinterface

// File: hdl/command_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Marks each character of a command line with its token membership and index.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                               | size
//  --------+-----+-------------------------------------------------------+-----
//  req_if  | in  | character, line_last                                  | 17 b
//  rsp_if  | out | in_token, token_start, token_index, operator_token,   | 12 b
//          |     | line_end                                              |
//
//  One beat in per cycle, one beat out per cycle, while the result is not
//  stalled; input register, then scanner logic into the result register.
//  The scanner state updates as a beat moves into the result register.
//  A stalled result holds; the input stage keeps filling until both stages
//  are full. Synchronous reset clears valids and the scanner state.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top import cltok_pkg::*; #(
   parameter int MAX_TOKENS = 256
) (
   input  logic       clock,
   input  logic       reset,
   cltok_req_if.sink  req_if,
   cltok_rsp_if.source rsp_if
);

   // highest token index: smaller of MAX_TOKENS - 1 and 255
   localparam logic [INDEX_W-1:0] INDEX_CAP =
      (MAX_TOKENS - 1 > 255) ? 8'd255 : INDEX_W'(MAX_TOKENS - 1);

   logic          s1_valid_ff;
   req_beat_type  s1_beat_ff;
   logic          rsp_valid_ff;
   rsp_beat_type  rsp_beat_ff;

   scan_mode_type mode_ff, mode_in;
   logic          caret_ff;
   logic [INDEX_W-1:0] count_ff, count_in;
   logic          seen_ff, seen_in;

   logic          s1_advance;
   logic          blank, op_char, quote;
   logic          member, start;
   rsp_beat_type  rsp_beat_in;

   // handshake: result register drains or is empty
   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         s1_beat_ff.character <= req_if.character;
         s1_beat_ff.line_last <= req_if.line_last;
      end
   end

   // character classes
   assign blank   = (s1_beat_ff.character == CHAR_SPACE) || (s1_beat_ff.character == CHAR_TAB);
   assign op_char = (s1_beat_ff.character == CHAR_EQ)   || (s1_beat_ff.character == CHAR_LT) ||
                    (s1_beat_ff.character == CHAR_GT)   || (s1_beat_ff.character == CHAR_PIPE) ||
                    (s1_beat_ff.character == CHAR_AMP);
   assign quote   = (s1_beat_ff.character == CHAR_QUOTE);

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_BETWEEN: begin
            if (blank)        mode_in = MODE_BETWEEN;
            else if (op_char) mode_in = MODE_OPERATOR;
            else if (quote)   mode_in = MODE_QUOTED;
            else              mode_in = MODE_WORD;
         end
         MODE_WORD: begin
            if (blank)                    mode_in = MODE_BETWEEN;
            else if (op_char && !caret_ff) mode_in = MODE_OPERATOR;
            else if (quote)               mode_in = MODE_QUOTED;
            else                          mode_in = MODE_WORD;
         end
         MODE_QUOTED: begin
            if (quote) mode_in = MODE_WORD;
            else       mode_in = MODE_QUOTED;
         end
         MODE_OPERATOR: begin
            if (blank)        mode_in = MODE_BETWEEN;
            else if (op_char) mode_in = MODE_OPERATOR;
            else if (quote)   mode_in = MODE_QUOTED;
            else              mode_in = MODE_WORD;
         end
         default: mode_in = MODE_BETWEEN;
      endcase
   end

   // per-character marks
   always_comb begin
      member = 1'b1;
      start  = 1'b0;
      unique case (mode_ff)
         MODE_BETWEEN: begin
            member = !blank;
            start  = !blank;
         end
         MODE_WORD: begin
            member = !blank;
            start  = op_char && !caret_ff;
         end
         MODE_QUOTED: begin
            member = 1'b1;
            start  = 1'b0;
         end
         MODE_OPERATOR: begin
            member = !blank;
            start  = !blank && !op_char;
         end
         default: begin
            member = 1'b0;
            start  = 1'b0;
         end
      endcase
   end

   // token counter: first token keeps index zero, later ones count up to the cap
   always_comb begin
      count_in = count_ff;
      seen_in  = seen_ff || start;
      if (start && seen_ff && (count_ff < INDEX_CAP)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_beat_in.in_token       = member;
      rsp_beat_in.token_start    = start;
      rsp_beat_in.token_index    = member ? count_in : '0;
      rsp_beat_in.operator_token = member && (mode_in == MODE_OPERATOR);
      rsp_beat_in.line_end       = s1_beat_ff.line_last;
   end

   // scanner state; end of line returns to the reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         caret_ff <= 1'b0;
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else if (s1_advance) begin
         if (s1_beat_ff.line_last) begin
            mode_ff  <= MODE_BETWEEN;
            caret_ff <= 1'b0;
            count_ff <= '0;
            seen_ff  <= 1'b0;
         end else begin
            mode_ff  <= mode_in;
            caret_ff <= (s1_beat_ff.character == CHAR_CARET);
            count_ff <= count_in;
            seen_ff  <= seen_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_advance) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.in_token       = rsp_beat_ff.in_token;
   assign rsp_if.token_start    = rsp_beat_ff.token_start;
   assign rsp_if.token_index    = rsp_beat_ff.token_index;
   assign rsp_if.operator_token = rsp_beat_ff.operator_token;
   assign rsp_if.line_end       = rsp_beat_ff.line_end;

endmodule

// File: hdl/cltok_checker.sv
// ----------------------------------------------------------------------------
// cltok_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_top_assert.svh"

module cltok_checker import cltok_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               in_token,
   input logic               token_start,
   input logic [INDEX_W-1:0] token_index,
   input logic               operator_token
);

   // a blank carries no token marks
   `CLTOK_ASSERT_IMPLY(a_blank_clean, clock, reset, rsp_valid && !in_token, !token_start && (token_index == '0) && !operator_token, "blank beat with token marks")

   // a token start or operator mark lies inside a token
   `CLTOK_ASSERT_IMPLY(a_marks_in_token, clock, reset, rsp_valid && (token_start || operator_token), in_token, "token mark outside a token")

   // a stalled beat stays
   `CLTOK_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // nothing comes out right after reset
   `CLTOK_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid || reset, "result valid after reset")

endmodule

bind command_line_tokenizer_top cltok_checker u_cltok_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .in_token       (rsp_if.in_token),
   .token_start    (rsp_if.token_start),
   .token_index    (rsp_if.token_index),
   .operator_token (rsp_if.operator_token)
);
